[rtl/core/sli_pkg.sv]
// ----------------------------------------------------------------------------
// sli_pkg
// Shared sizes, operation codes and status codes for the sorted list store.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_t;

endpackage

[rtl/core/sli_ram.sv]
// ----------------------------------------------------------------------------
// sli_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sli_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/sorted_list_insert_delete.sv]
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Sorted store of signed 32-bit values with insert, delete-at and read-at.
// ----------------------------------------------------------------------------
// The entries live in one RAM with registered read data and are kept in
// ascending order; equal values keep their arrival order. One request is
// worked at a time and each gives one response carrying the count after the
// operation. An insert walks down from the top, moving one larger entry up
// per cycle past the k entries larger than the value; into an empty list it
// writes slot 0 directly. A delete at position p of n entries closes the gap
// one entry per cycle, moving the n - p - 1 entries above p; removing the last
// entry only lowers the count. The one RAM write port moves one entry per
// cycle. The next request is taken while an earlier response still waits on
// rsp_stall.
module sorted_list_insert_delete (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [sli_pkg::OP_W-1:0]            operation,
  input  logic signed [sli_pkg::DATA_W-1:0]   value,
  input  logic [sli_pkg::POS_W-1:0]           position,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic signed [sli_pkg::DATA_W-1:0]   read_value,
  output logic [sli_pkg::COUNT_W-1:0]         count,
  output logic [sli_pkg::STATUS_W-1:0]        status
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INS  = 6'b000010,
    S_PUT  = 6'b000100,
    S_DEL  = 6'b001000,
    S_READ = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                             state, state_next;
  logic [sli_pkg::ADDR_W-1:0]         idx, idx_next;
  logic [sli_pkg::CNT_W-1:0]          fill, fill_next;
  logic signed [sli_pkg::DATA_W-1:0]  ins_val, ins_val_next;
  logic signed [sli_pkg::DATA_W-1:0]  res_value, res_value_next;
  sli_pkg::status_t                   res_status, res_status_next;

  logic                               wr_en, rd_en;
  logic [sli_pkg::ADDR_W-1:0]         wr_addr, rd_addr;
  logic [sli_pkg::DATA_W-1:0]         wr_data, rd_data;

  logic [sli_pkg::CMP_W-1:0]          pos_ext, fill_ext;
  logic                               bad_pos, rsp_free;

  sli_ram #(
    .DEPTH (sli_pkg::CAPACITY),
    .WIDTH (sli_pkg::DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign pos_ext   = sli_pkg::CMP_W'(position);
  assign fill_ext  = sli_pkg::CMP_W'(fill);
  assign bad_pos   = (pos_ext >= fill_ext);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    fill_next       = fill;
    ins_val_next    = ins_val;
    res_value_next  = res_value;
    res_status_next = res_status;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;
    rd_en           = 1'b0;
    rd_addr         = '0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ins_val_next    = value;
          res_value_next  = '0;
          res_status_next = sli_pkg::ST_OK;
          state_next      = S_DONE;
          unique case (sli_pkg::op_t'(operation))
            sli_pkg::OP_INSERT: begin
              if (fill >= sli_pkg::CNT_W'(sli_pkg::CAPACITY)) begin
                res_status_next = sli_pkg::ST_FULL;
              end else if (fill == '0) begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = value;
                fill_next = fill + sli_pkg::CNT_W'(1);
              end else begin
                // start the walk at the top entry
                idx_next   = fill[sli_pkg::ADDR_W-1:0];
                rd_en      = 1'b1;
                rd_addr    = fill[sli_pkg::ADDR_W-1:0] - sli_pkg::ADDR_W'(1);
                state_next = S_INS;
              end
            end
            sli_pkg::OP_DELETE: begin
              if (bad_pos) begin
                res_status_next = sli_pkg::ST_BADPOS;
              end else if (pos_ext + sli_pkg::CMP_W'(1) >= fill_ext) begin
                fill_next = fill - sli_pkg::CNT_W'(1);
              end else begin
                idx_next   = pos_ext[sli_pkg::ADDR_W-1:0];
                rd_en      = 1'b1;
                rd_addr    = pos_ext[sli_pkg::ADDR_W-1:0] + sli_pkg::ADDR_W'(1);
                state_next = S_DEL;
              end
            end
            sli_pkg::OP_READ: begin
              if (bad_pos) begin
                res_status_next = sli_pkg::ST_BADPOS;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = pos_ext[sli_pkg::ADDR_W-1:0];
                state_next = S_READ;
              end
            end
            sli_pkg::OP_NOP: begin
            end
          endcase
        end
      end

      S_INS: begin
        // rd_data holds the entry just below slot idx
        if ($signed(rd_data) > ins_val) begin
          wr_en    = 1'b1;
          wr_addr  = idx;
          wr_data  = rd_data;
          idx_next = idx - sli_pkg::ADDR_W'(1);
          if (idx == sli_pkg::ADDR_W'(1)) begin
            state_next = S_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx - sli_pkg::ADDR_W'(2);
          end
        end else begin
          wr_en      = 1'b1;
          wr_addr    = idx;
          wr_data    = ins_val;
          fill_next  = fill + sli_pkg::CNT_W'(1);
          state_next = S_DONE;
        end
      end

      S_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = idx;
        wr_data    = ins_val;
        fill_next  = fill + sli_pkg::CNT_W'(1);
        state_next = S_DONE;
      end

      S_DEL: begin
        // move entry idx+1 down into idx
        wr_en    = 1'b1;
        wr_addr  = idx;
        wr_data  = rd_data;
        idx_next = idx + sli_pkg::ADDR_W'(1);
        if (sli_pkg::CNT_W'(idx) + sli_pkg::CNT_W'(2) < fill) begin
          rd_en   = 1'b1;
          rd_addr = idx + sli_pkg::ADDR_W'(2);
        end else begin
          fill_next  = fill - sli_pkg::CNT_W'(1);
          state_next = S_DONE;
        end
      end

      S_READ: begin
        res_value_next = rd_data;
        state_next     = S_DONE;
      end

      S_DONE: begin
        // hold until the response register is free
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    ins_val    <= ins_val_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && rsp_free) begin
      read_value <= res_value;
      count      <= sli_pkg::COUNT_W'(fill);
      status     <= res_status;
    end
  end

endmodule

[bench/sorted_list_insert_delete_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_test
// Self-checking bench for the sorted store: a queue-fed driver offers insert,
// delete, read and no-op requests in random bursts, a shadow sorted list
// predicts every response, and a monitor compares each accepted response
// field by field while the response side stalls on its own pattern.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_test;

  typedef struct {
    bit                                 drain;  // pause until all responses are back
    sli_pkg::op_t                       op;
    logic signed [sli_pkg::DATA_W-1:0]  val;
    logic [sli_pkg::POS_W-1:0]          pos;
  } request_t;

  typedef struct {
    logic signed [sli_pkg::DATA_W-1:0]  rd;
    logic [sli_pkg::COUNT_W-1:0]        cnt;
    sli_pkg::status_t                   st;
  } response_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 req_valid = 1'b0;
  logic                                 req_stall;
  logic [sli_pkg::OP_W-1:0]             operation = sli_pkg::OP_NOP;
  logic signed [sli_pkg::DATA_W-1:0]    value = '0;
  logic [sli_pkg::POS_W-1:0]            position = '0;
  logic                                 rsp_valid;
  logic                                 rsp_stall = 1'b0;
  logic signed [sli_pkg::DATA_W-1:0]    read_value;
  logic [sli_pkg::COUNT_W-1:0]          count;
  logic [sli_pkg::STATUS_W-1:0]         status;

  sorted_list_insert_delete uut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .operation  (operation),
    .value      (value),
    .position   (position),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .read_value (read_value),
    .count      (count),
    .status     (status)
  );

  request_t                             pending_requests[$];
  response_t                            awaited_responses[$];
  logic signed [sli_pkg::DATA_W-1:0]    shadow_list [sli_pkg::CAPACITY];
  int                                   shadow_fill = 0;
  int                                   planned_fill = 0;
  int                                   fault_count = 0;
  int                                   responses_seen = 0;
  logic                                 req_taken = 1'b0;

  // sender pacing
  int                                   burst_left = 0;
  int                                   idle_left = 0;
  // receiver pacing
  int                                   hold_left = 0;
  int                                   holds_done = 0;
  int                                   mode = 0;
  int                                   mode_left = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Apply one request to the shadow list and return the response it gives.
  function automatic response_t apply_to_shadow_list(request_t r);
    response_t res;
    int        slot;
    res.rd = '0;
    res.st = sli_pkg::ST_OK;
    unique case (r.op)
      sli_pkg::OP_INSERT: begin
        if (shadow_fill >= sli_pkg::CAPACITY) begin
          res.st = sli_pkg::ST_FULL;
        end else begin
          slot = shadow_fill;
          // equal values stay ahead of the new one
          while (slot > 0 && shadow_list[slot-1] > r.val) begin
            shadow_list[slot] = shadow_list[slot-1];
            slot--;
          end
          shadow_list[slot] = r.val;
          shadow_fill++;
        end
      end
      sli_pkg::OP_DELETE, sli_pkg::OP_READ: begin
        if (r.pos >= shadow_fill) begin
          res.st = sli_pkg::ST_BADPOS;
        end else if (r.op == sli_pkg::OP_DELETE) begin
          for (int i = r.pos; i + 1 < shadow_fill; i++) begin
            shadow_list[i] = shadow_list[i+1];
          end
          shadow_fill--;
        end else begin
          res.rd = shadow_list[r.pos];
        end
      end
      default: ;
    endcase
    res.cnt = sli_pkg::COUNT_W'(shadow_fill);
    return res;
  endfunction

  task automatic queue_request(sli_pkg::op_t op, logic signed [sli_pkg::DATA_W-1:0] v,
                               logic [sli_pkg::POS_W-1:0] p);
    request_t r;
    r.drain = 1'b0;
    r.op    = op;
    r.val   = v;
    r.pos   = p;
    pending_requests.push_back(r);
    // track the fill level so positions can aim inside the list
    if (op == sli_pkg::OP_INSERT && planned_fill < sli_pkg::CAPACITY) planned_fill++;
    if (op == sli_pkg::OP_DELETE && p < planned_fill) planned_fill--;
  endtask

  task automatic queue_drain();
    request_t r;
    r.drain = 1'b1;
    r.op    = sli_pkg::OP_NOP;
    r.val   = '0;
    r.pos   = '0;
    pending_requests.push_back(r);
  endtask

  function automatic logic signed [sli_pkg::DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return $urandom;
    if (roll < 80) return $urandom_range(0, 20) - 10;  // dense range for duplicates
    if (roll < 88) return 32'sh7fffffff;
    if (roll < 96) return 32'sh80000000;
    return 0;
  endfunction

  function automatic logic [sli_pkg::POS_W-1:0] pick_position();
    int top;
    top = (planned_fill > 16) ? 15 : planned_fill - 1;
    if (planned_fill > 0 && $urandom_range(0, 99) < 85) begin
      return sli_pkg::POS_W'($urandom_range(0, top));
    end
    return sli_pkg::POS_W'($urandom_range(0, 15));
  endfunction

  // Driver: present the head of the request queue in bursts.
  always @(negedge clk) begin : drive_requests
    request_t nxt;
    logic     take;
    if (!rst && (!req_valid || req_taken)) begin
      take = 1'b0;
      if (pending_requests.size() != 0 && pending_requests[0].drain) begin
        if (awaited_responses.size() == 0) void'(pending_requests.pop_front());
      end else if (idle_left != 0) begin
        idle_left--;
      end else if (pending_requests.size() != 0) begin
        nxt = pending_requests.pop_front();
        take = 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 12);
        burst_left--;
        if (burst_left == 0) begin
          idle_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      req_valid <= take;
      if (take) begin
        operation <= nxt.op;
        value     <= nxt.val;
        position  <= nxt.pos;
      end
    end
  end

  // Receiver: stall on a pattern of changing density, with two long hold-offs.
  always @(negedge clk) begin : pace_responses
    logic hold;
    if (hold_left != 0) begin
      hold_left--;
      hold = 1'b1;
    end else if (holds_done < 2 && responses_seen >= (holds_done == 0 ? 120 : 330)) begin
      hold_left = 80;
      holds_done++;
      hold = 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      unique case (mode)
        0:       hold = 1'b0;
        1:       hold = ($urandom_range(0, 3) == 0);
        default: hold = ($urandom_range(0, 3) != 0);
      endcase
    end
    rsp_stall <= hold;
  end

  // Monitor: check each response, then predict the request accepted at this edge.
  always @(posedge clk) begin : check_responses
    response_t want;
    request_t  got;
    req_taken <= !rst && req_valid && !req_stall;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        responses_seen <= responses_seen + 1;
        if (awaited_responses.size() == 0) begin
          $error("response with none expected: read_value %0d count %0d status %0d",
                 read_value, count, status);
          fault_count++;
        end else begin
          want = awaited_responses.pop_front();
          if (read_value !== want.rd) begin
            $error("read_value expected %0d got %0d", want.rd, read_value);
            fault_count++;
          end
          if (count !== want.cnt) begin
            $error("count expected %0d got %0d", want.cnt, count);
            fault_count++;
          end
          if (status !== want.st) begin
            $error("status expected %0d got %0d", want.st, status);
            fault_count++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        got.drain = 1'b0;
        got.op    = sli_pkg::op_t'(operation);
        got.val   = value;
        got.pos   = position;
        awaited_responses.push_back(apply_to_shadow_list(got));
      end
    end
  end

  initial begin
    #4800000;
    $display("sorted_list_insert_delete_test: errors");
    $finish;
  end

  initial begin
    int           made;
    int           phase;
    int           span;
    int           roll;
    sli_pkg::op_t op;

    // empty list, no-op, extremes, duplicates, first/last/out-of-range positions
    queue_request(sli_pkg::OP_READ,   0, 0);
    queue_request(sli_pkg::OP_DELETE, 0, 0);
    queue_request(sli_pkg::OP_NOP,    32'sh7fffffff, 15);
    queue_request(sli_pkg::OP_INSERT, 32'sh7fffffff, 0);
    queue_request(sli_pkg::OP_INSERT, 32'sh80000000, 15);
    queue_request(sli_pkg::OP_INSERT, 0, 0);
    queue_request(sli_pkg::OP_INSERT, 0, 0);
    queue_request(sli_pkg::OP_INSERT, -1, 0);
    queue_request(sli_pkg::OP_INSERT, 5, 0);
    queue_request(sli_pkg::OP_READ,   0, 0);
    queue_request(sli_pkg::OP_READ,   0, 5);
    queue_request(sli_pkg::OP_READ,   0, 6);
    queue_request(sli_pkg::OP_READ,   0, 15);
    queue_request(sli_pkg::OP_DELETE, 0, 5);
    queue_request(sli_pkg::OP_DELETE, 0, 0);
    queue_request(sli_pkg::OP_READ,   0, 2);
    queue_request(sli_pkg::OP_DELETE, 0, 1);
    queue_request(sli_pkg::OP_INSERT, 32'sh80000000, 0);
    queue_request(sli_pkg::OP_READ,   0, 0);
    queue_request(sli_pkg::OP_DELETE, 0, 9);
    queue_drain();

    // random phases that fill the list, empty it, or mix
    made = 0;
    while (made < 480) begin
      phase = $urandom_range(0, 2);
      span  = $urandom_range(20, 60);
      repeat (span) begin
        roll = $urandom_range(0, 99);
        unique case (phase)
          0:       op = (roll < 70) ? sli_pkg::OP_INSERT :
                        (roll < 85) ? sli_pkg::OP_DELETE :
                        (roll < 97) ? sli_pkg::OP_READ : sli_pkg::OP_NOP;
          1:       op = (roll < 20) ? sli_pkg::OP_INSERT :
                        (roll < 75) ? sli_pkg::OP_DELETE :
                        (roll < 97) ? sli_pkg::OP_READ : sli_pkg::OP_NOP;
          default: op = (roll < 40) ? sli_pkg::OP_INSERT :
                        (roll < 65) ? sli_pkg::OP_DELETE :
                        (roll < 95) ? sli_pkg::OP_READ : sli_pkg::OP_NOP;
        endcase
        queue_request(op, pick_value(), pick_position());
        made++;
      end
      if ($urandom_range(0, 2) == 0) queue_drain();
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || (req_valid && !req_taken) ||
           awaited_responses.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    if (fault_count == 0 && awaited_responses.size() == 0) begin
      $display("sorted_list_insert_delete_test: clean");
    end else begin
      $display("sorted_list_insert_delete_test: errors");
    end
    $finish;
  end

endmodule
